// ===== rtl/pfa_pkg.sv =====
// pfa_pkg: shared constants, types and modular helpers for the prime field alu
// no dependencies
`timescale 1ns / 1ps

package pfa_pkg;

    // element width and step counter width
    localparam int DATA_WIDTH = 31;
    localparam int CNT_W      = $clog2(DATA_WIDTH);
    localparam logic [DATA_WIDTH-1:0] MOD_RESET = DATA_WIDTH'(2147483647);

    // operation codes
    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_NEG = 3'd4,
        OP_INV = 3'd5,
        OP_EQ  = 3'd6,
        OP_NOP = 3'd7
    } t_opcode;

    // status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_ZERO   = 2'd1;
    localparam logic [1:0] ST_NO_INV = 2'd2;

    // request to the divider
    typedef struct packed {
        logic                  start;
        logic [DATA_WIDTH-1:0] dividend;
        logic [DATA_WIDTH-1:0] divisor;
    } t_div_req;

    // request to the modular multiplier
    typedef struct packed {
        logic                  start;
        logic [DATA_WIDTH-1:0] mult_a;
        logic [DATA_WIDTH-1:0] mult_b;
    } t_mul_req;

    // (x + y) mod m with x, y < m
    function automatic logic [DATA_WIDTH-1:0] add_mod(
        input logic [DATA_WIDTH-1:0] x,
        input logic [DATA_WIDTH-1:0] y,
        input logic [DATA_WIDTH-1:0] m
    );
        logic [DATA_WIDTH:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, m}) begin
            s = s - {1'b0, m};
        end
        return s[DATA_WIDTH-1:0];
    endfunction

    // (x - y) mod m with x, y < m
    function automatic logic [DATA_WIDTH-1:0] sub_mod(
        input logic [DATA_WIDTH-1:0] x,
        input logic [DATA_WIDTH-1:0] y,
        input logic [DATA_WIDTH-1:0] m
    );
        logic [DATA_WIDTH:0] d;
        d = {1'b0, x} - {1'b0, y};
        if (x < y) begin
            d = d + {1'b0, m};
        end
        return d[DATA_WIDTH-1:0];
    endfunction

endpackage

// ===== rtl/pfa_div.sv =====
// pfa_div: restoring divider, one quotient bit per cycle
// depends on pfa_pkg
`timescale 1ns / 1ps

module pfa_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  pfa_pkg::t_div_req               i_req,
    output logic                            o_done,
    output logic [pfa_pkg::DATA_WIDTH-1:0]  o_quot,
    output logic [pfa_pkg::DATA_WIDTH-1:0]  o_rem
);

    logic                            r_busy;
    logic                            r_done;
    logic [pfa_pkg::CNT_W-1:0]       r_cnt;
    logic [pfa_pkg::DATA_WIDTH-1:0]  r_quot;
    logic [pfa_pkg::DATA_WIDTH-1:0]  r_rem;
    logic [pfa_pkg::DATA_WIDTH-1:0]  r_den;
    logic [pfa_pkg::DATA_WIDTH:0]    w_trial;
    logic                            w_fit;

    // trial subtract of the next partial remainder
    assign w_trial = {r_rem, r_quot[pfa_pkg::DATA_WIDTH-1]};
    assign w_fit   = (w_trial >= {1'b0, r_den});

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= pfa_pkg::CNT_W'(pfa_pkg::DATA_WIDTH - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quot <= i_req.dividend;
            r_rem  <= '0;
            r_den  <= i_req.divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[pfa_pkg::DATA_WIDTH-2:0], w_fit};
            if (w_fit) begin
                r_rem <= pfa_pkg::DATA_WIDTH'(w_trial - {1'b0, r_den});
            end else begin
                r_rem <= w_trial[pfa_pkg::DATA_WIDTH-1:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

// ===== rtl/pfa_mul.sv =====
// pfa_mul: modular multiplier by double-and-add, a doubling phase and an add phase per operand bit
// depends on pfa_pkg
`timescale 1ns / 1ps

module pfa_mul (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  pfa_pkg::t_mul_req               i_req,
    input  logic [pfa_pkg::DATA_WIDTH-1:0]  i_mod,
    output logic                            o_done,
    output logic [pfa_pkg::DATA_WIDTH-1:0]  o_prod
);

    logic                            r_busy;
    logic                            r_done;
    logic                            r_phase;
    logic [pfa_pkg::CNT_W-1:0]       r_cnt;
    logic [pfa_pkg::DATA_WIDTH-1:0]  r_acc;
    logic [pfa_pkg::DATA_WIDTH-1:0]  r_a;
    logic [pfa_pkg::DATA_WIDTH-1:0]  r_b;
    logic [pfa_pkg::DATA_WIDTH-1:0]  w_addend;

    // phase 0 doubles, phase 1 adds a when the current bit of b is set
    assign w_addend = r_phase ? r_a : r_acc;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_phase <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy  <= 1'b1;
                r_phase <= 1'b0;
                r_cnt   <= pfa_pkg::CNT_W'(pfa_pkg::DATA_WIDTH - 1);
            end else if (r_busy) begin
                r_phase <= ~r_phase;
                if (r_phase) begin
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                end
            end
        end
    end

    // accumulator
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_acc <= '0;
            r_a   <= i_req.mult_a;
            r_b   <= i_req.mult_b;
        end else if (r_busy) begin
            if (!r_phase || r_b[pfa_pkg::DATA_WIDTH-1]) begin
                r_acc <= pfa_pkg::add_mod(r_acc, w_addend, i_mod);
            end
            if (r_phase) begin
                r_b <= {r_b[pfa_pkg::DATA_WIDTH-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

// ===== rtl/prime_field_alu.sv =====
// prime_field_alu: top level, sequencer around a divider and a modular multiplier
// depends on pfa_pkg, pfa_div, pfa_mul
`timescale 1ns / 1ps

// channel   dir  fields (low bit first)
// s_axis    in   opcode[2:0], operand_a[33:3], operand_b[64:34]
// m_axis    out  result_value[30:0], equal_flag[31], status[33:32]
// apb       in   modulus at byte address 0
//
// unless the modulus is below 2, operands are reduced first (two divider runs);
// add, subtract, negate and equal then finish in the dispatch state, multiply after one multiplier run.
// divide and invert run extended euclid: each round takes one divider run and
// one multiplier run, up to about 45 rounds for 31 bits.
// reset is synchronous and active low; the modulus resets to 2^31 - 1.
// a finished result waits in the output register while m_axis_tready is low.

module prime_field_alu (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // opcode, operand_a, operand_b
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,
    // result_value, equal_flag, status
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int W = pfa_pkg::DATA_WIDTH;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_RED_A = 9'b000000010,
        S_RED_B = 9'b000000100,
        S_DISP  = 9'b000001000,
        S_TEST  = 9'b000010000,
        S_EDIV  = 9'b000100000,
        S_EMUL  = 9'b001000000,
        S_FMUL  = 9'b010000000,
        S_FIN   = 9'b100000000
    } t_state;

    t_state            r_state, n_state;
    logic [W-1:0]      r_mod;
    pfa_pkg::t_opcode  r_op, n_op;
    logic [W-1:0]      r_a, n_a, r_b, n_b;
    logic [W-1:0]      r_rp, n_rp, r_rc, n_rc, r_cp, n_cp, r_cc, n_cc, r_rs, n_rs;
    logic [W-1:0]      r_res, n_res;
    logic              r_eq, n_eq;
    logic [1:0]        r_st, n_st;
    logic              r_ovalid;
    logic [39:0]       r_odata;
    logic              w_in_xfer;
    logic              w_out_load;
    pfa_pkg::t_div_req w_div_req;
    pfa_pkg::t_mul_req w_mul_req;
    logic              w_div_done, w_mul_done;
    logic [W-1:0]      w_quot, w_rem, w_prod;

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {1'b0, r_mod} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod <= pfa_pkg::MOD_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
            r_mod <= pwdata[W-1:0];
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;
    assign w_out_load    = (r_state == S_FIN) && (!r_ovalid || m_axis_tready);

    // shared units
    pfa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_done  (w_div_done),
        .o_quot  (w_quot),
        .o_rem   (w_rem)
    );

    pfa_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mul_req),
        .i_mod   (r_mod),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        n_op = r_op; n_a = r_a; n_b = r_b;
        n_rp = r_rp; n_rc = r_rc; n_cp = r_cp; n_cc = r_cc; n_rs = r_rs;
        n_res = r_res; n_eq = r_eq; n_st = r_st;
        w_div_req = '0;
        w_mul_req = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_op  = pfa_pkg::t_opcode'(s_axis_tdata[2:0]);
                    n_a   = s_axis_tdata[33:3];
                    n_b   = s_axis_tdata[64:34];
                    n_res = '0;
                    n_eq  = 1'b0;
                    n_st  = pfa_pkg::ST_OK;
                    if (r_mod < W'(2)) begin
                        n_state = S_FIN;
                    end else begin
                        w_div_req.start    = 1'b1;
                        w_div_req.dividend = s_axis_tdata[33:3];
                        w_div_req.divisor  = r_mod;
                        n_state = S_RED_A;
                    end
                end
            end
            S_RED_A: begin
                if (w_div_done) begin
                    n_a = w_rem;
                    w_div_req.start    = 1'b1;
                    w_div_req.dividend = r_b;
                    w_div_req.divisor  = r_mod;
                    n_state = S_RED_B;
                end
            end
            S_RED_B: begin
                if (w_div_done) begin
                    n_b = w_rem;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                n_state = S_FIN;
                n_rp = r_mod;
                n_cp = '0;
                n_cc = W'(1);
                unique case (r_op)
                    pfa_pkg::OP_ADD: n_res = pfa_pkg::add_mod(r_a, r_b, r_mod);
                    pfa_pkg::OP_SUB: n_res = pfa_pkg::sub_mod(r_a, r_b, r_mod);
                    pfa_pkg::OP_NEG: n_res = (r_a == '0) ? '0 : r_mod - r_a;
                    pfa_pkg::OP_EQ:  n_eq  = (r_a == r_b);
                    pfa_pkg::OP_MUL: begin
                        w_mul_req.start  = 1'b1;
                        w_mul_req.mult_a = r_a;
                        w_mul_req.mult_b = r_b;
                        n_state = S_FMUL;
                    end
                    pfa_pkg::OP_DIV: begin
                        if (r_b == '0) begin
                            n_st = pfa_pkg::ST_ZERO;
                        end else begin
                            n_rc = r_b;
                            n_state = S_TEST;
                        end
                    end
                    pfa_pkg::OP_INV: begin
                        if (r_a == '0) begin
                            n_st = pfa_pkg::ST_ZERO;
                        end else begin
                            n_rc = r_a;
                            n_state = S_TEST;
                        end
                    end
                    pfa_pkg::OP_NOP: n_res = '0;
                    default: n_res = '0;
                endcase
            end
            // euclid loop test: stop once the remainder is one
            S_TEST: begin
                if (r_rc > W'(1)) begin
                    w_div_req.start    = 1'b1;
                    w_div_req.dividend = r_rp;
                    w_div_req.divisor  = r_rc;
                    n_state = S_EDIV;
                end else if (r_op == pfa_pkg::OP_DIV) begin
                    w_mul_req.start  = 1'b1;
                    w_mul_req.mult_a = r_a;
                    w_mul_req.mult_b = r_cc;
                    n_state = S_FMUL;
                end else begin
                    n_res = r_cc;
                    n_state = S_FIN;
                end
            end
            S_EDIV: begin
                if (w_div_done) begin
                    if (w_rem == '0) begin
                        // common factor with the modulus: no inverse
                        n_st = pfa_pkg::ST_NO_INV;
                        if (r_op == pfa_pkg::OP_DIV) begin
                            w_mul_req.start  = 1'b1;
                            w_mul_req.mult_a = r_a;
                            w_mul_req.mult_b = r_b;
                            n_state = S_FMUL;
                        end else begin
                            n_res = r_a;
                            n_state = S_FIN;
                        end
                    end else begin
                        n_rs = w_rem;
                        w_mul_req.start  = 1'b1;
                        w_mul_req.mult_a = w_quot;
                        w_mul_req.mult_b = r_cc;
                        n_state = S_EMUL;
                    end
                end
            end
            S_EMUL: begin
                if (w_mul_done) begin
                    n_cc = pfa_pkg::sub_mod(r_cp, w_prod, r_mod);
                    n_cp = r_cc;
                    n_rp = r_rc;
                    n_rc = r_rs;
                    n_state = S_TEST;
                end
            end
            S_FMUL: begin
                if (w_mul_done) begin
                    n_res = w_prod;
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and working registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op; r_a <= n_a; r_b <= n_b;
        r_rp <= n_rp; r_rc <= n_rc; r_cp <= n_cp; r_cc <= n_cc; r_rs <= n_rs;
        r_res <= n_res; r_eq <= n_eq; r_st <= n_st;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_out_load) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_odata <= {6'd0, r_st, r_eq, r_res};
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    // checks
    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("state not one-hot");
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[33:32] != 2'd3)) else $error("bad status");
    a_eq_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[31]) |-> (m_axis_tdata[30:0] == '0))
        else $error("equal flag with nonzero result");
    a_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (r_mod >= W'(2))) |-> (m_axis_tdata[30:0] < r_mod))
        else $error("result not reduced");
    a_unit_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_div_req.start && w_mul_req.start)) else $error("both units started");

endmodule
